// ===== rtl/pfm_pkg.sv =====
// shared constants and control types for the pcm frame mixdown block
// no dependencies; imported by pfm_dp, pfm_ctrl, pcm_frame_mixdown and the testbench
`default_nettype none

package pfm_pkg;

  localparam int DEF_MAX_CHANNELS  = 8;
  localparam int DEF_FRACTION_BITS = 23;

  localparam int SAMPLE_W   = 32;
  localparam int OUT_W      = 25;
  localparam int OUT_DATA_W = 32;
  localparam int BPS_W      = 3;
  localparam int NCH_W      = 4;
  localparam int NORM_W     = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_SAMPLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS     = 2'd1;

  localparam logic [BPS_W-1:0] BPS_RESET = 3'd2;
  localparam logic [NCH_W-1:0] NCH_RESET = 4'd2;

  typedef struct packed {
    logic acc;   // add the accepted item into the frame sum
    logic prep;  // latch magnitude, sign and divisor, clear the frame sum
    logic step;  // one restoring divide step
    logic load;  // move the signed quotient into the output register
  } pfm_cmd_t;

  typedef struct packed {
    logic last;  // accepted item closes the frame
  } pfm_stat_t;

endpackage

`default_nettype wire

// ===== rtl/pfm_dp.sv =====
// datapath: config registers, sample extension, frame accumulator,
// restoring divider and output register; uses pfm_pkg
`default_nettype none

module pfm_dp #(
  parameter int MAX_CHANNELS  = pfm_pkg::DEF_MAX_CHANNELS,
  parameter int FRACTION_BITS = pfm_pkg::DEF_FRACTION_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [pfm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pfm_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic [pfm_pkg::SAMPLE_W-1:0]          raw_sample,
  input  pfm_pkg::pfm_cmd_t                     cmd,
  output pfm_pkg::pfm_stat_t                    stat,
  output logic signed [pfm_pkg::OUT_W-1:0]      mono_sample
);
  import pfm_pkg::*;

  localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
  localparam int SUM_W = 33 + $clog2(MAX_CHANNELS);
  localparam int D_W   = NORM_W + CH_W;
  localparam int R_W   = D_W + 1;
  localparam int Q_W   = FRACTION_BITS + 1;

  logic [BPS_W-1:0]        bps_r, bps_nxt;
  logic [NCH_W-1:0]        nch_r, nch_nxt;
  logic [CH_W-1:0]         ch_r, ch_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [D_W-1:0]          d_r, d_nxt;
  logic [R_W-1:0]          rem_r, rem_nxt;
  logic [Q_W-1:0]          q_r, q_nxt;
  logic                    neg_r, neg_nxt;
  logic signed [OUT_W-1:0] mono_r, mono_nxt;

  logic [1:0]              nb_m1;
  logic [CH_W-1:0]         chans;
  logic signed [31:0]      samp;
  logic [NORM_W-1:0]       norm;
  logic [SUM_W-1:0]        mag;
  logic [R_W:0]            diff;
  logic                    ge;
  logic [R_W-1:0]          keep;
  logic signed [Q_W:0]     qs;
  logic                    cfg_hit;

  always_comb begin
    if (bps_r == '0) begin
      nb_m1 = 2'd0;
    end else if (bps_r > 3'd4) begin
      nb_m1 = 2'd3;
    end else begin
      nb_m1 = 2'(bps_r - 3'd1);
    end
    if (nch_r == '0) begin
      chans = CH_W'(1);
    end else if (32'(nch_r) > MAX_CHANNELS) begin
      chans = CH_W'(MAX_CHANNELS);
    end else begin
      chans = CH_W'(nch_r);
    end
  end

  always_comb begin
    case (nb_m1)
      2'd0: begin
        samp = {24'd0, raw_sample[7:0]};
        norm = NORM_W'(255);
      end
      2'd1: begin
        samp = {{16{raw_sample[15]}}, raw_sample[15:0]};
        norm = NORM_W'(32767);
      end
      2'd2: begin
        samp = {{8{raw_sample[23]}}, raw_sample[23:0]};
        norm = NORM_W'(8388607);
      end
      default: begin
        samp = raw_sample;
        norm = {NORM_W{1'b1}};
      end
    endcase
  end

  assign stat.last = ({1'b0, ch_r} + 1'b1) >= {1'b0, chans};
  assign cfg_hit   = cfg_we && (cfg_index == REG_BYTES_PER_SAMPLE ||
                                cfg_index == REG_NUM_CHANNELS);

  assign mag  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign diff = {1'b0, rem_r} - {2'b00, d_r};
  assign ge   = !diff[R_W];
  assign keep = ge ? diff[R_W-1:0] : rem_r;
  assign qs   = neg_r ? -signed'({1'b0, q_r}) : signed'({1'b0, q_r});

  always_comb begin
    bps_nxt  = bps_r;
    nch_nxt  = nch_r;
    ch_nxt   = ch_r;
    sum_nxt  = sum_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    neg_nxt  = neg_r;
    mono_nxt = mono_r;
    if (cmd.acc) begin
      sum_nxt = sum_r + {{(SUM_W-32){samp[31]}}, samp};
      ch_nxt  = stat.last ? '0 : CH_W'(ch_r + 1'b1);
    end
    if (cmd.prep) begin
      neg_nxt = sum_r[SUM_W-1];
      rem_nxt = R_W'(mag);
      d_nxt   = {{CH_W{1'b0}}, norm} * {{NORM_W{1'b0}}, chans};
      q_nxt   = '0;
      sum_nxt = '0;
    end
    if (cmd.step) begin
      rem_nxt = {keep[R_W-2:0], 1'b0};
      q_nxt   = {q_r[Q_W-2:0], ge};
    end
    if (cmd.load) begin
      mono_nxt = OUT_W'(qs);
    end
    if (cfg_we && cfg_index == REG_BYTES_PER_SAMPLE) begin
      bps_nxt = cfg_data[BPS_W-1:0];
    end
    if (cfg_we && cfg_index == REG_NUM_CHANNELS) begin
      nch_nxt = cfg_data[NCH_W-1:0];
    end
    if (cfg_hit) begin
      ch_nxt  = '0;
      sum_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bps_r <= BPS_RESET;
      nch_r <= NCH_RESET;
      ch_r  <= '0;
      sum_r <= '0;
    end else begin
      bps_r <= bps_nxt;
      nch_r <= nch_nxt;
      ch_r  <= ch_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r    <= d_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    neg_r  <= neg_nxt;
    mono_r <= mono_nxt;
  end

  assign mono_sample = mono_r;

endmodule

`default_nettype wire

// ===== rtl/pfm_ctrl.sv =====
// controller: accept / prepare / divide / hold sequencer and output valid
// drives datapath commands; uses pfm_pkg
`default_nettype none

module pfm_ctrl #(
  parameter int FRACTION_BITS = pfm_pkg::DEF_FRACTION_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  pfm_pkg::pfm_stat_t stat,
  output pfm_pkg::pfm_cmd_t  cmd
);
  import pfm_pkg::*;

  localparam int CNT_W = $clog2(FRACTION_BITS + 1);

  localparam logic [1:0] S_ACC  = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovld_r, ovld_nxt;

  assign in_tready  = (state_r == S_ACC);
  assign out_tvalid = ovld_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ovld_nxt  = ovld_r && !out_tready;
    cmd       = '0;
    case (state_r)
      S_ACC: begin
        if (in_tvalid) begin
          cmd.acc = 1'b1;
          if (stat.last) begin
            state_nxt = S_PREP;
          end
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = CNT_W'(cnt_r + 1'b1);
        if (cnt_r == CNT_W'(FRACTION_BITS)) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!ovld_r || out_tready) begin
          cmd.load  = 1'b1;
          ovld_nxt  = 1'b1;
          state_nxt = S_ACC;
        end
      end
      default: begin
        state_nxt = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
      cnt_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pcm_frame_mixdown.sv =====
// Mixes interleaved PCM channel samples down to one mono value per frame,
// as the truncated frame mean in two's complement with FRACTION_BITS
// fraction bits. Every item that does not close a frame is accepted
// without a stall. The item that closes a frame starts a restoring divide
// of one quotient bit per cycle, so the input stays stalled through the
// prepare step, the divide steps and the hold state until the result is
// loaded into the output register. The result sits in that output
// register and the next frame is gathered while it waits. A config write
// drops any partly gathered frame and is meant for an idle block.
// top level: instantiates pfm_ctrl and pfm_dp; uses pfm_pkg
`default_nettype none

module pcm_frame_mixdown #(
  parameter int MAX_CHANNELS  = pfm_pkg::DEF_MAX_CHANNELS,
  parameter int FRACTION_BITS = pfm_pkg::DEF_FRACTION_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [pfm_pkg::SAMPLE_W-1:0]       in_tdata,    // [31:0] raw_sample
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [pfm_pkg::OUT_DATA_W-1:0]     out_tdata,   // [24:0] mono_sample, rest zero
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pfm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pfm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pfm_pkg::*;

  pfm_cmd_t                cmd;
  pfm_stat_t               stat;
  logic signed [OUT_W-1:0] mono_sample;

  assign cfg_ready = 1'b1;
  assign out_tdata = {{(OUT_DATA_W-OUT_W){1'b0}}, mono_sample};

  pfm_ctrl #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  pfm_dp #(
    .MAX_CHANNELS  (MAX_CHANNELS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .raw_sample  (in_tdata),
    .cmd         (cmd),
    .stat        (stat),
    .mono_sample (mono_sample)
  );

endmodule

`default_nettype wire

// ===== rtl/pfm_checker.sv =====
// port-level checks for pcm_frame_mixdown, attached by bind
// depends on the top level's port list only
`default_nettype none

module pfm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("out item changed while stalled");

  // input stalls only right after an accepted item closed a frame
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(in_tready) |-> $past(in_tvalid))
    else $error("input stalled without an accepted item");

  // input reopens exactly when the frame result is presented
  a_reopen_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(in_tready) |-> out_tvalid)
    else $error("input reopened without a result");

  // a new result only appears after the divide held the input off
  a_result_after_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a divide");

endmodule

bind pcm_frame_mixdown pfm_checker u_pfm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// testbench for pcm_frame_mixdown: directed and random pcm frames checked against a
// built-in mixdown predictor; stream handshakes with random idle bursts on both sides
// depends on pfm_pkg and pcm_frame_mixdown
`timescale 1ns / 100ps

module testbench;

  import pfm_pkg::*;

  localparam int MAXCH    = DEF_MAX_CHANNELS;
  localparam int FRAC     = DEF_FRACTION_BITS;
  localparam int PAUSE    = 40;
  localparam int WDOG_MAX = 2000;
  localparam int PHASES   = 12;
  localparam int PHASE_N  = 121;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [SAMPLE_W-1:0]    in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // predictor state
  logic [BPS_W-1:0]       mix_bps;
  logic [NCH_W-1:0]       mix_nch;
  int unsigned            mix_chan;
  longint                 mix_sum;

  logic [OUT_DATA_W-1:0]  pending_mono[$];
  logic [OUT_DATA_W-1:0]  mono_exp;
  int                     mismatch_count = 0;
  int                     wdog_count = 0;
  bit                     idle_en = 1'b1;

  always #4 clk = ~clk;

  pcm_frame_mixdown DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  function automatic int unsigned eff_bytes();
    if (mix_bps == 0) return 1;
    if (mix_bps > 4) return 4;
    return 32'(mix_bps);
  endfunction

  function automatic int unsigned eff_channels();
    if (mix_nch == 0) return 1;
    if (mix_nch > MAXCH) return MAXCH;
    return 32'(mix_nch);
  endfunction

  function automatic void mix_channel_sample(input logic [SAMPLE_W-1:0] raw);
    int unsigned       nb;
    int unsigned       bits;
    longint unsigned   chans;
    longint unsigned   mask;
    longint unsigned   v;
    longint unsigned   half;
    longint unsigned   norm;
    longint unsigned   mag;
    longint unsigned   q;
    longint            smp;
    logic [63:0]       r;
    bit                neg;
    nb    = eff_bytes();
    bits  = nb * 8;
    chans = 64'(eff_channels());
    mask  = (64'd1 << bits) - 1;
    v     = 64'(raw) & mask;
    if (nb == 1) begin
      smp  = longint'(v);
      norm = 255;
    end else begin
      half = 64'd1 << (bits - 1);
      if ((v & half) != 0) smp = longint'(v) - longint'(64'd1 << bits);
      else smp = longint'(v);
      norm = half - 1;
    end
    mix_sum  += smp;
    mix_chan += 1;
    if (64'(mix_chan) < chans) return;
    neg = (mix_sum < 0);
    if (neg) mag = $unsigned(-mix_sum);
    else mag = $unsigned(mix_sum);
    q = (mag << FRAC) / (norm * chans);
    r = neg ? (64'd0 - q) : q;
    pending_mono.push_back({{(OUT_DATA_W-OUT_W){1'b0}}, r[OUT_W-1:0]});
    mix_chan = 0;
    mix_sum  = 0;
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_raw();
    int unsigned     nb;
    longint unsigned mask;
    logic [31:0]     hi;
    nb   = eff_bytes();
    mask = (64'd1 << (nb * 8)) - 1;
    hi   = $urandom & ~mask[31:0];
    case ($urandom_range(0, 5))
      0: return hi | (nb == 1 ? mask[31:0] : mask[31:0] >> 1);
      1: return hi | (nb == 1 ? 32'd0 : 32'd1 << (nb * 8 - 1));
      2: return hi;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [OUT_DATA_W-1:0] got,
                                 input logic [OUT_DATA_W-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] raw);
    @(negedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= raw;
    do @(posedge clk); while (!in_tready);
    mix_channel_sample(raw);
  endtask

  // stop input and let every pending result drain
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_mono.size() != 0) @(posedge clk);
    repeat (PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_BYTES_PER_SAMPLE) begin
      mix_bps  = val[BPS_W-1:0];
      mix_chan = 0;
      mix_sum  = 0;
    end else if (idx == REG_NUM_CHANNELS) begin
      mix_nch  = val;
      mix_chan = 0;
      mix_sum  = 0;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] bps, input logic [CFG_DATA_W-1:0] nch);
    settle();
    write_reg(REG_BYTES_PER_SAMPLE, bps);
    write_reg(REG_NUM_CHANNELS, nch);
  endtask

  task automatic test_default_config();
    send_sample(32'h0000_7fff);
    send_sample(32'hffff_7fff);
    send_sample(32'hffff_8000);
    send_sample(32'h1234_8000);
  endtask

  task automatic test_sample_widths();
    set_config(4'd1, 4'd1);
    send_sample(32'hffff_ffff);
    send_sample(32'hffff_ff00);
    set_config(4'd3, 4'd1);
    send_sample(32'h0080_0000);
    send_sample(32'hff7f_ffff);
    set_config(4'd4, 4'd1);
    send_sample(32'h8000_0000);
    send_sample(32'h7fff_ffff);
  endtask

  // zero and oversized register values
  task automatic test_out_of_range_config();
    set_config(4'd0, 4'd0);
    send_sample(32'hffff_ff80);
    set_config(4'd15, 4'd15);
    repeat (8) send_sample(32'h8000_0000);
  endtask

  task automatic test_frame_drop_on_write();
    set_config(4'd2, 4'd3);
    send_sample(32'h0000_7fff);
    send_sample(32'h0000_7fff);
    settle();
    write_reg(REG_NUM_CHANNELS, 4'd3);
    send_sample(32'h0000_8000);
    send_sample(32'h0000_0001);
    send_sample(32'h0000_ffff);
  endtask

  task automatic test_unknown_register();
    set_config(4'd2, 4'd2);
    send_sample(32'h0000_4000);
    settle();
    write_reg(REG_UNUSED_A, 4'($urandom));
    send_sample(32'h0000_c000);
  endtask

  task automatic test_random_phases();
    logic [CFG_DATA_W-1:0] bps;
    logic [CFG_DATA_W-1:0] nch;
    int                    sent;
    int                    part;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        bps = 4'd1;
        nch = 4'd1;
      end else if (ph == 1) begin
        bps = 4'd4;
        nch = 4'd8;
      end else begin
        bps = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(1, 4)) : 4'($urandom_range(0, 7));
        bps[3] = 1'($urandom_range(0, 1));
        nch = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(0, 15));
      end
      if (ph == PHASES - 1) idle_en = 1'b0;
      settle();
      if ($urandom_range(0, 1)) begin
        write_reg(REG_BYTES_PER_SAMPLE, bps);
        write_reg(REG_NUM_CHANNELS, nch);
      end else begin
        write_reg(REG_NUM_CHANNELS, nch);
        write_reg(REG_BYTES_PER_SAMPLE, bps);
      end
      sent = 0;
      while (sent < PHASE_N) begin
        if ($urandom_range(0, 149) == 0) begin
          settle();
          write_reg($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B, 4'($urandom));
        end
        send_sample(rand_raw());
        sent++;
      end
      // broken frame left behind for the next register write to drop
      if ($urandom_range(0, 2) == 0 && eff_channels() > 1) begin
        part = $urandom_range(1, eff_channels() - 1);
        repeat (part) send_sample(rand_raw());
      end
    end
  endtask

  initial begin
    out_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (idle_en && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_mono.size() == 0) begin
        report_mismatch("unexpected item", out_tdata, '0);
      end else begin
        mono_exp = pending_mono.pop_front();
        if (out_tdata[OUT_W-1:0] !== mono_exp[OUT_W-1:0])
          report_mismatch("mono_sample", out_tdata, mono_exp);
        if (out_tdata[OUT_DATA_W-1:OUT_W] !== '0)
          report_mismatch("padding", out_tdata, mono_exp);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        wdog_count <= 0;
      else
        wdog_count <= wdog_count + 1;
      if (wdog_count >= WDOG_MAX) begin
        $display("watchdog expired at %0t", $realtime);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    mix_bps   = BPS_RESET;
    mix_nch   = NCH_RESET;
    mix_chan  = 0;
    mix_sum   = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_config();
    test_sample_widths();
    test_out_of_range_config();
    test_frame_drop_on_write();
    test_unknown_register();
    test_random_phases();

    settle();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
